[hdl/gno_pkg.sv]
// ----------------------------------------------------------------------------
// gno_pkg
// Shared types, constants and table functions for the 3D gradient noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package gno_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int STEP_FRAC   = 16;
  localparam int TABLE_SIZE  = 256;
  localparam int MAX_OCTAVES = 8;
  localparam int NV_W        = FRAC_BITS + 4;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;

  typedef enum logic [2:0] {
    REG_AMPLITUDE    = 3'd0,
    REG_FREQ_X       = 3'd1,
    REG_FREQ_Y       = 3'd2,
    REG_FREQ_Z       = 3'd3,
    REG_PERSISTENCE  = 3'd4,
    REG_FREQ_STEP    = 3'd5,
    REG_OCTAVE_COUNT = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SCALE,
    OP_FADE_SQ,
    OP_FADE_CUBE,
    OP_FADE_POLY,
    OP_FADE_MUL,
    OP_MIX_U0,
    OP_MIX_U1,
    OP_MIX_V,
    OP_MIX_W,
    OP_ACCUM,
    OP_FINAL
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FADE_SQ,
    ST_FADE_CUBE,
    ST_FADE_POLY,
    ST_FADE_MUL,
    ST_MIX_U0,
    ST_MIX_U1,
    ST_MIX_V,
    ST_MIX_W,
    ST_ACCUM,
    ST_FINAL
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [3:0] octave_count;
  } stat_t;

  localparam logic [7:0] PERM_TBL [TABLE_SIZE] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] i);
    return PERM_TBL[i];
  endfunction

  // gradient dot product; the selector takes z for the non-special codes
  function automatic logic signed [NV_W-1:0] grad(input logic [3:0] h,
                                                  input logic signed [NV_W-1:0] x,
                                                  input logic signed [NV_W-1:0] y,
                                                  input logic signed [NV_W-1:0] z);
    logic signed [NV_W-1:0] u;
    logic signed [NV_W-1:0] v;
    logic signed [NV_W-1:0] su;
    logic signed [NV_W-1:0] sv;
    u = h[3] ? y : x;
    if (h inside {4'd0, 4'd1, 4'd2, 4'd3}) begin
      v = y;
    end else if (h inside {4'd12, 4'd14}) begin
      v = x;
    end else begin
      v = z;
    end
    su = h[0] ? -u : u;
    sv = h[1] ? -v : v;
    return su + sv;
  endfunction

  function automatic logic [31:0] sat_s32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sd2147483647);
    lo = PROD_W'(-64'sd2147483648);
    if (v > hi) begin
      return 32'h7fff_ffff;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

[hdl/gradient_noise_3d_octaves.sv]
// The octave count is clamped to 1..MAX_OCTAVES (8 by default).
// One item in flight at a time.
// Each octave takes ten steps through three shared multiplier lanes.
// The result register holds a finished item until it is taken.
// Reset (rst_n low, synchronous) returns to idle and loads register defaults.
// ----------------------------------------------------------------------------
// gradient_noise_3d_octaves
// Multi-octave 3D gradient noise on a Q16.16 position, amplitude-scaled.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_3d_octaves #(
  parameter int MAX_OCTAVES = gno_pkg::MAX_OCTAVES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_noise_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  gno_pkg::cmd_t  cmd;
  gno_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  gno_ctrl #(
    .MAX_OCTAVES(MAX_OCTAVES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gno_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_noise_value(out_noise_value)
  );

endmodule

`default_nettype wire

[hdl/gno_ctrl.sv]
// ----------------------------------------------------------------------------
// gno_ctrl
// Sequencer: steps the datapath through each octave and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module gno_ctrl #(
  parameter int MAX_OCTAVES = gno_pkg::MAX_OCTAVES
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire gno_pkg::stat_t stat,
  output gno_pkg::cmd_t       cmd
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

  gno_pkg::state_t  state_r, state_nxt;
  logic [OCT_W-1:0] oct_r, oct_nxt;
  logic [OCT_W-1:0] n_oct;
  logic             out_valid_r, out_valid_nxt;
  logic             last_oct;
  logic             out_free;

  always_comb begin
    if (stat.octave_count == 4'd0) begin
      n_oct = OCT_W'(1);
    end else if (int'(stat.octave_count) > MAX_OCTAVES) begin
      n_oct = OCT_W'(MAX_OCTAVES);
    end else begin
      n_oct = OCT_W'(stat.octave_count);
    end
  end

  assign last_oct = (oct_r + OCT_W'(1)) == n_oct;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gno_pkg::ST_IDLE:      if (in_valid) state_nxt = gno_pkg::ST_SCALE;
      gno_pkg::ST_SCALE:     state_nxt = gno_pkg::ST_FADE_SQ;
      gno_pkg::ST_FADE_SQ:   state_nxt = gno_pkg::ST_FADE_CUBE;
      gno_pkg::ST_FADE_CUBE: state_nxt = gno_pkg::ST_FADE_POLY;
      gno_pkg::ST_FADE_POLY: state_nxt = gno_pkg::ST_FADE_MUL;
      gno_pkg::ST_FADE_MUL:  state_nxt = gno_pkg::ST_MIX_U0;
      gno_pkg::ST_MIX_U0:    state_nxt = gno_pkg::ST_MIX_U1;
      gno_pkg::ST_MIX_U1:    state_nxt = gno_pkg::ST_MIX_V;
      gno_pkg::ST_MIX_V:     state_nxt = gno_pkg::ST_MIX_W;
      gno_pkg::ST_MIX_W:     state_nxt = gno_pkg::ST_ACCUM;
      gno_pkg::ST_ACCUM:     state_nxt = last_oct ? gno_pkg::ST_FINAL : gno_pkg::ST_SCALE;
      gno_pkg::ST_FINAL:     if (out_free) state_nxt = gno_pkg::ST_IDLE;
      default:               state_nxt = gno_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = gno_pkg::OP_IDLE;
    in_ready      = 1'b0;
    oct_nxt       = oct_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      gno_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op  = gno_pkg::OP_LOAD;
          oct_nxt = '0;
        end
      end
      gno_pkg::ST_SCALE:     cmd.op = gno_pkg::OP_SCALE;
      gno_pkg::ST_FADE_SQ:   cmd.op = gno_pkg::OP_FADE_SQ;
      gno_pkg::ST_FADE_CUBE: cmd.op = gno_pkg::OP_FADE_CUBE;
      gno_pkg::ST_FADE_POLY: cmd.op = gno_pkg::OP_FADE_POLY;
      gno_pkg::ST_FADE_MUL:  cmd.op = gno_pkg::OP_FADE_MUL;
      gno_pkg::ST_MIX_U0:    cmd.op = gno_pkg::OP_MIX_U0;
      gno_pkg::ST_MIX_U1:    cmd.op = gno_pkg::OP_MIX_U1;
      gno_pkg::ST_MIX_V:     cmd.op = gno_pkg::OP_MIX_V;
      gno_pkg::ST_MIX_W:     cmd.op = gno_pkg::OP_MIX_W;
      gno_pkg::ST_ACCUM: begin
        cmd.op  = gno_pkg::OP_ACCUM;
        oct_nxt = oct_r + OCT_W'(1);
      end
      gno_pkg::ST_FINAL: begin
        if (out_free) begin
          cmd.op        = gno_pkg::OP_FINAL;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = gno_pkg::OP_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gno_pkg::ST_IDLE;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oct_r       <= oct_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/gno_dpath.sv]
// ----------------------------------------------------------------------------
// gno_dpath
// Three multiplier lanes, lattice hash, gradients, blend, accumulate, config.
// ----------------------------------------------------------------------------
`default_nettype none

module gno_dpath (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire gno_pkg::cmd_t cmd,
  output gno_pkg::stat_t   stat,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic [31:0]      out_noise_value
);

  localparam int F  = gno_pkg::FRAC_BITS;
  localparam int S  = gno_pkg::STEP_FRAC;
  localparam int NV = gno_pkg::NV_W;
  localparam int MW = gno_pkg::MUL_W;
  localparam int PW = gno_pkg::PROD_W;
  localparam int QW = F + 6;
  localparam logic signed [QW-1:0] Q_OFF  = QW'(15 << F);
  localparam logic signed [QW-1:0] TEN    = QW'(10 << F);
  localparam logic signed [NV-1:0] NV_ONE = NV'(1 << F);
  localparam logic signed [NV-1:0] NV_HALF = NV'(1 << (F - 1));

  // configuration
  logic signed [31:0] amp_cfg_r;
  logic signed [31:0] fbase_r [3];
  logic [17:0]        pers_r;
  logic [17:0]        fstep_r;
  logic [3:0]         octc_r;

  // per-item state
  logic signed [31:0] pos_r  [3];
  logic signed [31:0] freq_r [3];
  logic [31:0]        wgt_r;
  logic signed [31:0] acc_r;
  logic [7:0]         cell_r [3];
  logic [F-1:0]       frac_r [3];
  logic [F-1:0]       t2_r   [3];
  logic [F-1:0]       t3_r   [3];
  logic signed [QW-1:0] poly_r [3];
  logic [F:0]         fade_r [3];
  logic [7:0]         ha_r, hb_r, haa_r, hab_r, hba_r, hbb_r;
  logic signed [NV-1:0] grad_r [8];
  logic signed [NV-1:0] mix_r  [4];
  logic signed [NV-1:0] lo_r, hi_r, nv_r;
  logic [31:0]        out_r;

  logic signed [MW-1:0] ma [3];
  logic signed [MW-1:0] mb [3];
  logic signed [PW-1:0] prod [3];
  logic signed [PW-1:0] sh [3];
  logic signed [QW-1:0] qv [3];
  logic signed [NV-1:0] gv [8];
  logic signed [NV-1:0] co0 [3];
  logic signed [NV-1:0] co1 [3];
  logic [7:0]           hsel [8];
  logic signed [NV-1:0] n01;
  logic signed [PW-1:0] acc_sum;

  function automatic logic signed [MW-1:0] zx_f(input logic [F:0] v);
    return {{(MW-F-1){1'b0}}, v};
  endfunction

  function automatic logic signed [MW-1:0] sx_d(input logic signed [NV:0] v);
    return {{(MW-NV-1){v[NV]}}, v};
  endfunction

  function automatic logic signed [MW-1:0] sx32(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  assign stat.octave_count = octc_r;
  assign out_noise_value   = out_r;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign prod[i] = ma[i] * mb[i];
    assign sh[i]   = prod[i] >>> F;
    assign qv[i]   = $signed({4'b0, frac_r[i], 2'b00}) + $signed({5'b0, frac_r[i], 1'b0})
                     - Q_OFF;
    assign co0[i]  = $signed({{(NV-F){1'b0}}, frac_r[i]});
    assign co1[i]  = co0[i] - NV_ONE;
  end

  always_comb begin
    hsel[0] = haa_r;
    hsel[1] = hba_r;
    hsel[2] = hab_r;
    hsel[3] = hbb_r;
    hsel[4] = haa_r + 8'd1;
    hsel[5] = hba_r + 8'd1;
    hsel[6] = hab_r + 8'd1;
    hsel[7] = hbb_r + 8'd1;
  end

  for (genvar k = 0; k < 8; k++) begin : g_grad
    logic [7:0] hv;
    assign hv    = gno_pkg::perm(hsel[k]);
    assign gv[k] = gno_pkg::grad(hv[3:0],
                                 ((k & 1) != 0) ? co1[0] : co0[0],
                                 ((k & 2) != 0) ? co1[1] : co0[1],
                                 ((k & 4) != 0) ? co1[2] : co0[2]);
  end

  assign n01     = (nv_r >>> 1) + NV_HALF;
  assign acc_sum = {{(PW-32){acc_r[31]}}, acc_r} + sh[0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (cmd.op)
      gno_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = sx32(pos_r[i]);
          mb[i] = sx32(freq_r[i]);
        end
      end
      gno_pkg::OP_FADE_SQ: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = zx_f({1'b0, frac_r[i]});
          mb[i] = zx_f({1'b0, frac_r[i]});
        end
      end
      gno_pkg::OP_FADE_CUBE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = zx_f({1'b0, t2_r[i]});
          mb[i] = zx_f({1'b0, frac_r[i]});
        end
      end
      gno_pkg::OP_FADE_POLY: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = zx_f({1'b0, frac_r[i]});
          mb[i] = {{(MW-QW){qv[i][QW-1]}}, qv[i]};
        end
      end
      gno_pkg::OP_FADE_MUL: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = zx_f({1'b0, t3_r[i]});
          mb[i] = {{(MW-QW){poly_r[i][QW-1]}}, poly_r[i]};
        end
      end
      gno_pkg::OP_MIX_U0: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = zx_f(fade_r[0]);
          mb[i] = sx_d((NV+1)'(grad_r[2*i+1]) - (NV+1)'(grad_r[2*i]));
        end
      end
      gno_pkg::OP_MIX_U1: begin
        ma[0] = zx_f(fade_r[0]);
        mb[0] = sx_d((NV+1)'(grad_r[7]) - (NV+1)'(grad_r[6]));
        ma[1] = sx32(freq_r[0]);
        mb[1] = {{(MW-18){1'b0}}, fstep_r};
        ma[2] = sx32(freq_r[1]);
        mb[2] = {{(MW-18){1'b0}}, fstep_r};
      end
      gno_pkg::OP_MIX_V: begin
        ma[0] = zx_f(fade_r[1]);
        mb[0] = sx_d((NV+1)'(mix_r[1]) - (NV+1)'(mix_r[0]));
        ma[1] = zx_f(fade_r[1]);
        mb[1] = sx_d((NV+1)'(mix_r[3]) - (NV+1)'(mix_r[2]));
        ma[2] = sx32(freq_r[2]);
        mb[2] = {{(MW-18){1'b0}}, fstep_r};
      end
      gno_pkg::OP_MIX_W: begin
        ma[0] = zx_f(fade_r[2]);
        mb[0] = sx_d((NV+1)'(hi_r) - (NV+1)'(lo_r));
      end
      gno_pkg::OP_ACCUM: begin
        ma[0] = {{(MW-NV){n01[NV-1]}}, n01};
        mb[0] = {1'b0, wgt_r};
        ma[1] = {1'b0, wgt_r};
        mb[1] = {{(MW-18){1'b0}}, pers_r};
      end
      gno_pkg::OP_FINAL: begin
        ma[0] = sx32(acc_r);
        mb[0] = sx32(amp_cfg_r);
      end
      default: begin
        ma[0] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_cfg_r  <= 32'sd65536;
      fbase_r[0] <= 32'sd65536;
      fbase_r[1] <= 32'sd65536;
      fbase_r[2] <= 32'sd65536;
      pers_r     <= 18'd32768;
      fstep_r    <= 18'd131072;
      octc_r     <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        gno_pkg::REG_AMPLITUDE:    amp_cfg_r  <= cfg_data;
        gno_pkg::REG_FREQ_X:       fbase_r[0] <= cfg_data;
        gno_pkg::REG_FREQ_Y:       fbase_r[1] <= cfg_data;
        gno_pkg::REG_FREQ_Z:       fbase_r[2] <= cfg_data;
        gno_pkg::REG_PERSISTENCE:  pers_r     <= cfg_data[17:0];
        gno_pkg::REG_FREQ_STEP:    fstep_r    <= cfg_data[17:0];
        gno_pkg::REG_OCTAVE_COUNT: octc_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      gno_pkg::OP_LOAD: begin
        pos_r[0] <= in_pos_x;
        pos_r[1] <= in_pos_y;
        pos_r[2] <= in_pos_z;
        for (int i = 0; i < 3; i++) freq_r[i] <= fbase_r[i];
        wgt_r <= 32'(1 << S);
        acc_r <= '0;
      end
      gno_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          cell_r[i] <= sh[i][F+7:F];
          frac_r[i] <= sh[i][F-1:0];
        end
      end
      gno_pkg::OP_FADE_SQ: begin
        for (int i = 0; i < 3; i++) t2_r[i] <= sh[i][F-1:0];
        ha_r <= gno_pkg::perm(cell_r[0]) + cell_r[1];
        hb_r <= gno_pkg::perm(cell_r[0] + 8'd1) + cell_r[1];
      end
      gno_pkg::OP_FADE_CUBE: begin
        for (int i = 0; i < 3; i++) t3_r[i] <= sh[i][F-1:0];
        haa_r <= gno_pkg::perm(ha_r) + cell_r[2];
        hab_r <= gno_pkg::perm(ha_r + 8'd1) + cell_r[2];
        hba_r <= gno_pkg::perm(hb_r) + cell_r[2];
        hbb_r <= gno_pkg::perm(hb_r + 8'd1) + cell_r[2];
      end
      gno_pkg::OP_FADE_POLY: begin
        for (int i = 0; i < 3; i++) poly_r[i] <= sh[i][QW-1:0] + TEN;
        for (int k = 0; k < 8; k++) grad_r[k] <= gv[k];
      end
      gno_pkg::OP_FADE_MUL: begin
        for (int i = 0; i < 3; i++) fade_r[i] <= sh[i][F:0];
      end
      gno_pkg::OP_MIX_U0: begin
        for (int i = 0; i < 3; i++) mix_r[i] <= grad_r[2*i] + sh[i][NV-1:0];
      end
      gno_pkg::OP_MIX_U1: begin
        mix_r[3]  <= grad_r[6] + sh[0][NV-1:0];
        freq_r[0] <= gno_pkg::sat_s32(prod[1] >>> S);
        freq_r[1] <= gno_pkg::sat_s32(prod[2] >>> S);
      end
      gno_pkg::OP_MIX_V: begin
        lo_r      <= mix_r[0] + sh[0][NV-1:0];
        hi_r      <= mix_r[2] + sh[1][NV-1:0];
        freq_r[2] <= gno_pkg::sat_s32(prod[2] >>> S);
      end
      gno_pkg::OP_MIX_W: begin
        nv_r <= lo_r + sh[0][NV-1:0];
      end
      gno_pkg::OP_ACCUM: begin
        acc_r <= gno_pkg::sat_s32(acc_sum);
        if (|prod[1][PW-1:S+32]) begin
          wgt_r <= 32'hffff_ffff;
        end else begin
          wgt_r <= prod[1][S+31:S];
        end
      end
      gno_pkg::OP_FINAL: begin
        out_r <= gno_pkg::sat_s32(sh[0]);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/gno_checker.sv]
// ----------------------------------------------------------------------------
// gno_checker
// Port-level checks for the gradient noise block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gno_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [31:0] in_pos_x,
  input wire logic [31:0] in_pos_y,
  input wire logic [31:0] in_pos_z,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_noise_value,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [2:0]  cfg_index,
  input wire logic [31:0] cfg_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("new item taken while one is in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
    else $error("result shown too early");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port stalled");

endmodule

bind gradient_noise_3d_octaves gno_checker u_gno_checker (.*);

`default_nettype wire
